[src/line_follow_pd_steering_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the line follower steering unit
// Shared property forms, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PD_STEERING_UNIT_MACROS_SVH
`define LINE_FOLLOW_PD_STEERING_UNIT_MACROS_SVH

// same-cycle implication
`define LFPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lfps_pkg.sv]
// ----------------------------------------------------------------------------
// lfps_pkg
// Constants, types and helper functions of the line follower steering unit.
// ----------------------------------------------------------------------------
package lfps_pkg;

    // sensor array
    localparam int SENSOR_COUNT = 8;
    localparam int SENSOR_IN_W  = 8;
    localparam int IDX_W        = $clog2(SENSOR_COUNT);
    localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
    localparam int WGT_W        = IDX_W + 1;
    // largest |sum of weights| is SENSOR_COUNT^2/4
    localparam int SUM_W        = $clog2(SENSOR_COUNT * SENSOR_COUNT / 4 + 1) + 1;
    localparam int MAG_W        = SUM_W - 1;

    // Q5.10 error path
    localparam int FRAC_W       = 10;
    localparam int FRAC_MASK    = (1 << FRAC_W) - 1;
    localparam int ERR_W        = 16;
    localparam int X_W          = MAG_W + FRAC_W;
    localparam int FP_W         = ERR_W + 11;
    localparam int DRV_W        = ERR_W + 6;

    // reciprocal divide
    localparam int RECIP_SHIFT  = 18;
    localparam int RECIP_W      = RECIP_SHIFT + 1;
    localparam int RECIP_ONE    = 1 << RECIP_SHIFT;

    // filter and steering gains
    localparam int FILT_OLD_COEF = 717;
    localparam int FILT_NEW_COEF = 307;
    localparam int STEER_KP      = 16;
    localparam int STEER_KD      = 8;
    localparam int SLOW_SHIFT    = FRAC_W - 2;

    // drive limits
    localparam int BASE_W           = 8;
    localparam int BASE_SPEED_RESET = 120;
    localparam int BASE_FLOOR       = 70;
    localparam int DRIVE_W          = 8;
    localparam int DRIVE_MIN        = 40;
    localparam int DRIVE_MAX        = 255;
    localparam int COUNT_OUT_W      = 4;
    localparam int COUNT_OUT_MAX    = 15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_DIV,
        ST_CORR,
        ST_FILT,
        ST_DRIVE
    } lfps_state_t;

    typedef struct packed {
        logic mult;
        logic corr;
    } lfps_div_ctrl_t;

    // floor(2^RECIP_SHIFT / h); zero for h = 0
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] h);
        logic [RECIP_W-1:0] r;
        case (32'(h))
            1:       r = RECIP_W'(RECIP_ONE);
            2:       r = RECIP_W'(RECIP_ONE / 2);
            3:       r = RECIP_W'(RECIP_ONE / 3);
            4:       r = RECIP_W'(RECIP_ONE / 4);
            5:       r = RECIP_W'(RECIP_ONE / 5);
            6:       r = RECIP_W'(RECIP_ONE / 6);
            7:       r = RECIP_W'(RECIP_ONE / 7);
            8:       r = RECIP_W'(RECIP_ONE / 8);
            9:       r = RECIP_W'(RECIP_ONE / 9);
            10:      r = RECIP_W'(RECIP_ONE / 10);
            11:      r = RECIP_W'(RECIP_ONE / 11);
            12:      r = RECIP_W'(RECIP_ONE / 12);
            13:      r = RECIP_W'(RECIP_ONE / 13);
            14:      r = RECIP_W'(RECIP_ONE / 14);
            15:      r = RECIP_W'(RECIP_ONE / 15);
            16:      r = RECIP_W'(RECIP_ONE / 16);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [DRIVE_W-1:0] clamp_drive(input logic signed [DRV_W-1:0] v);
        logic [DRIVE_W-1:0] d;
        if (v < DRV_W'(DRIVE_MIN)) begin
            d = DRIVE_W'(DRIVE_MIN);
        end
        else if (v > DRV_W'(DRIVE_MAX)) begin
            d = DRIVE_W'(DRIVE_MAX);
        end
        else begin
            d = DRIVE_W'(v);
        end
        return d;
    endfunction

    function automatic logic [COUNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [COUNT_OUT_W-1:0] s;
        if (32'(c) > COUNT_OUT_MAX) begin
            s = COUNT_OUT_W'(COUNT_OUT_MAX);
        end
        else begin
            s = COUNT_OUT_W'(c);
        end
        return s;
    endfunction

endpackage

[src/lfps_lane.sv]
// ----------------------------------------------------------------------------
// lfps_lane
// One sensor lane: captures the sensor's signed weight and its hit bit.
// ----------------------------------------------------------------------------
module lfps_lane (
    input  logic                               clk,
    input  logic                               load,
    input  logic                               sensor_bit,
    input  logic [lfps_pkg::IDX_W-1:0]         lane_idx,
    output logic signed [lfps_pkg::WGT_W-1:0]  weight,
    output logic                               hit
);

    localparam int LW = lfps_pkg::WGT_W + 2;

    logic signed [lfps_pkg::WGT_W-1:0] weight_reg;
    logic signed [lfps_pkg::WGT_W-1:0] weight_next;
    logic                              hit_reg;
    logic signed [LW-1:0]              lane_weight;

    // weight = 2*idx - (N-1)
    always_comb
    begin
        lane_weight = $signed({2'b00, lane_idx, 1'b0}) - LW'(lfps_pkg::SENSOR_COUNT - 1);
        weight_next = sensor_bit ? lfps_pkg::WGT_W'(lane_weight) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            weight_reg <= weight_next;
            hit_reg    <= sensor_bit;
        end
    end

    assign weight = weight_reg;
    assign hit    = hit_reg;

endmodule

[src/lfps_merge.sv]
// ----------------------------------------------------------------------------
// lfps_merge
// Combines the lanes: weight sum and active count, registered.
// ----------------------------------------------------------------------------
module lfps_merge (
    input  logic                               clk,
    input  logic                               load,
    input  logic signed [lfps_pkg::WGT_W-1:0]  weights [lfps_pkg::SENSOR_COUNT],
    input  logic                               hits    [lfps_pkg::SENSOR_COUNT],
    output logic signed [lfps_pkg::SUM_W-1:0]  sum,
    output logic [lfps_pkg::CNT_W-1:0]         count
);

    logic signed [lfps_pkg::SUM_W-1:0] sum_reg;
    logic signed [lfps_pkg::SUM_W-1:0] sum_next;
    logic [lfps_pkg::CNT_W-1:0]        count_reg;
    logic [lfps_pkg::CNT_W-1:0]        count_next;

    always_comb
    begin
        sum_next   = '0;
        count_next = '0;
        for (int i = 0; i < lfps_pkg::SENSOR_COUNT; i++)
        begin
            sum_next   = sum_next + lfps_pkg::SUM_W'(weights[i]);
            count_next = count_next + lfps_pkg::CNT_W'(hits[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    assign sum   = sum_reg;
    assign count = count_reg;

endmodule

[src/lfps_div.sv]
// ----------------------------------------------------------------------------
// lfps_div
// Two-step divide of sum*1024 by the active count, truncated toward zero:
// reciprocal multiply, then one compare-and-increment correction.
// ----------------------------------------------------------------------------
`include "line_follow_pd_steering_unit_macros.svh"

module lfps_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lfps_pkg::lfps_div_ctrl_t           ctrl,
    input  logic signed [lfps_pkg::SUM_W-1:0]  sum,
    input  logic [lfps_pkg::CNT_W-1:0]         count,
    output logic signed [lfps_pkg::ERR_W-1:0]  quot
);

    localparam int PW = lfps_pkg::X_W + lfps_pkg::RECIP_W;
    localparam int QW = lfps_pkg::X_W + lfps_pkg::CNT_W;

    logic [lfps_pkg::MAG_W-1:0]        sum_mag;
    logic [PW-1:0]                     recip_prod;
    logic [lfps_pkg::X_W-1:0]          x_reg;
    logic [lfps_pkg::X_W-1:0]          x_next;
    logic [lfps_pkg::X_W-1:0]          q0_reg;
    logic [lfps_pkg::X_W-1:0]          q0_next;
    logic [lfps_pkg::CNT_W-1:0]        h_reg;
    logic                              neg_reg;
    logic [QW-1:0]                     qh;
    logic [lfps_pkg::X_W-1:0]          rem;
    logic [lfps_pkg::X_W-1:0]          q_fix;
    logic signed [lfps_pkg::ERR_W-1:0] quot_reg;
    logic signed [lfps_pkg::ERR_W-1:0] quot_next;

    // step 1: q0 = floor(x * floor(2^18/h) / 2^18), at most one short
    always_comb
    begin
        sum_mag    = sum[lfps_pkg::SUM_W-1] ? lfps_pkg::MAG_W'(-sum) : lfps_pkg::MAG_W'(sum);
        x_next     = {sum_mag, {lfps_pkg::FRAC_W{1'b0}}};
        recip_prod = PW'(x_next) * PW'(lfps_pkg::recip(count));
        q0_next    = recip_prod[lfps_pkg::RECIP_SHIFT +: lfps_pkg::X_W];
    end

    // step 2: fix up by remainder, restore sign
    always_comb
    begin
        qh        = QW'(q0_reg) * QW'(h_reg);
        rem       = x_reg - lfps_pkg::X_W'(qh);
        q_fix     = q0_reg + lfps_pkg::X_W'(rem >= lfps_pkg::X_W'(h_reg));
        quot_next = neg_reg ? -lfps_pkg::ERR_W'(q_fix) : lfps_pkg::ERR_W'(q_fix);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mult)
        begin
            x_reg   <= x_next;
            q0_reg  <= q0_next;
            h_reg   <= count;
            neg_reg <= sum[lfps_pkg::SUM_W-1];
        end
        if (ctrl.corr)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

    // reciprocal estimate never more than one short
    `LFPS_ASSERT_IMPL(a_div_rem_bound, ctrl.corr && (h_reg != '0), rem < {h_reg, 1'b0}, "divide remainder out of range")

endmodule

[src/line_follow_pd_steering_unit.sv]
// ----------------------------------------------------------------------------
// line_follow_pd_steering_unit
// Line follower steering: weighted sensor centroid, low-pass filter and
// PD steering with curve slowdown, giving saturated left/right drives.
// ----------------------------------------------------------------------------
// Each input transfer carries one 8-bit line sensor sample (bit 0 = leftmost)
// and yields exactly one result transfer with the left and right drive levels
// (40..255), the number of active sensors and a line-lost flag. The result is
// registered after lane capture on the transfer edge, then lane merge, the
// reciprocal divide by the active count (multiply, then correction), the
// error filter and the drive stage. A new input transfer is taken as soon as
// the previous result is registered; a result that is not taken holds the
// next item in its drive stage. base_speed is written through
// cfg_write_en/cfg_write_data, resets to 120, and should only be written
// while the unit is idle.
// ----------------------------------------------------------------------------
`include "line_follow_pd_steering_unit_macros.svh"

module line_follow_pd_steering_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_write_en,
    input  logic [lfps_pkg::BASE_W-1:0]          cfg_write_data,
    // sensor sample
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [lfps_pkg::SENSOR_IN_W-1:0]     sensor_bits,
    // result
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [lfps_pkg::DRIVE_W-1:0]         left_drive,
    output logic [lfps_pkg::DRIVE_W-1:0]         right_drive,
    output logic [lfps_pkg::COUNT_OUT_W-1:0]     active_count,
    output logic                                 line_lost
);

    localparam int N = lfps_pkg::SENSOR_COUNT;

    // sequencer
    lfps_pkg::lfps_state_t state_reg;
    lfps_pkg::lfps_state_t state_next;
    logic                       lane_load;
    logic                       merge_load;
    logic                       filt_load;
    logic                       drive_load;
    lfps_pkg::lfps_div_ctrl_t   div_ctrl;

    // lanes and merge
    logic signed [lfps_pkg::WGT_W-1:0] lane_weight [N];
    logic                              lane_hit    [N];
    logic signed [lfps_pkg::SUM_W-1:0] merge_sum;
    logic [lfps_pkg::CNT_W-1:0]        merge_count;
    logic signed [lfps_pkg::ERR_W-1:0] div_quot;
    logic                              lost;

    // filter
    logic [lfps_pkg::BASE_W-1:0]        base_speed_reg;
    logic [lfps_pkg::BASE_W-1:0]        base_speed_next;
    logic signed [lfps_pkg::ERR_W-1:0]  filt_reg;
    logic signed [lfps_pkg::ERR_W-1:0]  filt_next;
    logic signed [lfps_pkg::ERR_W-1:0]  prev_reg;
    logic signed [lfps_pkg::ERR_W-1:0]  err_sel;
    logic signed [lfps_pkg::FP_W-1:0]   filt_prod;
    logic signed [lfps_pkg::ERR_W-1:0]  filt_calc;

    // drive
    logic signed [lfps_pkg::DRV_W-1:0]  steer_num;
    logic signed [lfps_pkg::DRV_W-1:0]  steer_bias;
    logic signed [lfps_pkg::DRV_W-1:0]  steer_val;
    logic [lfps_pkg::ERR_W-1:0]         filt_mag;
    logic [lfps_pkg::ERR_W-1:0]         slow;
    logic signed [lfps_pkg::DRV_W-1:0]  base_raw;
    logic signed [lfps_pkg::DRV_W-1:0]  base_sel;
    logic signed [lfps_pkg::DRV_W-1:0]  left_sum;
    logic signed [lfps_pkg::DRV_W-1:0]  right_sum;

    // result register
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [lfps_pkg::DRIVE_W-1:0]       left_drive_reg;
    logic [lfps_pkg::DRIVE_W-1:0]       right_drive_reg;
    logic [lfps_pkg::COUNT_OUT_W-1:0]   active_count_reg;
    logic                               line_lost_reg;

    // ------------------------------------------------------------------
    // lanes: one per sensor, captured on the input transfer
    // ------------------------------------------------------------------
    for (genvar g = 0; g < N; g++)
    begin : g_lane
        logic lane_bit;
        if (g < lfps_pkg::SENSOR_IN_W)
        begin : g_bit
            assign lane_bit = sensor_bits[g];
        end
        else
        begin : g_nobit
            assign lane_bit = 1'b0;
        end

        lfps_lane u_lane (
            .clk        (clk),
            .load       (lane_load),
            .sensor_bit (lane_bit),
            .lane_idx   (lfps_pkg::IDX_W'(g)),
            .weight     (lane_weight[g]),
            .hit        (lane_hit[g])
        );
    end

    lfps_merge u_merge (
        .clk     (clk),
        .load    (merge_load),
        .weights (lane_weight),
        .hits    (lane_hit),
        .sum     (merge_sum),
        .count   (merge_count)
    );

    lfps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .sum   (merge_sum),
        .count (merge_count),
        .quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfps_pkg::ST_IDLE:  if (in_valid) state_next = lfps_pkg::ST_MERGE;
            lfps_pkg::ST_MERGE: state_next = lfps_pkg::ST_DIV;
            lfps_pkg::ST_DIV:   state_next = lfps_pkg::ST_CORR;
            lfps_pkg::ST_CORR:  state_next = lfps_pkg::ST_FILT;
            lfps_pkg::ST_FILT:  state_next = lfps_pkg::ST_DRIVE;
            lfps_pkg::ST_DRIVE: if (!out_valid_reg || out_ready) state_next = lfps_pkg::ST_IDLE;
            default:            state_next = lfps_pkg::ST_IDLE;
        endcase
    end

    // sequencer: stage strobes
    always_comb
    begin
        lane_load     = 1'b0;
        merge_load    = 1'b0;
        div_ctrl      = '0;
        filt_load     = 1'b0;
        drive_load    = 1'b0;
        case (state_reg)
            lfps_pkg::ST_IDLE:  lane_load     = in_valid;
            lfps_pkg::ST_MERGE: merge_load    = 1'b1;
            lfps_pkg::ST_DIV:   div_ctrl.mult = 1'b1;
            lfps_pkg::ST_CORR:  div_ctrl.corr = 1'b1;
            lfps_pkg::ST_FILT:  filt_load     = 1'b1;
            // wait here while the previous result is still unclaimed
            lfps_pkg::ST_DRIVE: drive_load    = !out_valid_reg || out_ready;
            default:            ;
        endcase
    end

    assign in_ready = (state_reg == lfps_pkg::ST_IDLE);

    // ------------------------------------------------------------------
    // filter: filt = floor((717*old + 307*err) / 1024)
    // no line seen -> err is the old value, so the filter holds exactly
    // ------------------------------------------------------------------
    assign lost = (merge_count == '0);

    always_comb
    begin
        err_sel   = lost ? filt_reg : div_quot;
        filt_prod = lfps_pkg::FP_W'(filt_reg) * lfps_pkg::FP_W'(lfps_pkg::FILT_OLD_COEF)
                  + lfps_pkg::FP_W'(err_sel) * lfps_pkg::FP_W'(lfps_pkg::FILT_NEW_COEF);
        filt_calc = lfps_pkg::ERR_W'(filt_prod >>> lfps_pkg::FRAC_W);
        filt_next = filt_load ? filt_calc : filt_reg;
    end

    // ------------------------------------------------------------------
    // drive: steer = trunc((16*filt + 8*(filt - prev)) / 1024)
    //        base  = max(base_speed - floor(4*|filt|/1024), 70)
    // ------------------------------------------------------------------
    always_comb
    begin
        steer_num  = lfps_pkg::DRV_W'(filt_reg)
                     * lfps_pkg::DRV_W'(lfps_pkg::STEER_KP + lfps_pkg::STEER_KD)
                   - lfps_pkg::DRV_W'(prev_reg) * lfps_pkg::DRV_W'(lfps_pkg::STEER_KD);
        // bias negatives so the shift rounds toward zero
        steer_bias = steer_num[lfps_pkg::DRV_W-1] ? lfps_pkg::DRV_W'(lfps_pkg::FRAC_MASK) : '0;
        steer_val  = (steer_num + steer_bias) >>> lfps_pkg::FRAC_W;

        filt_mag   = filt_reg[lfps_pkg::ERR_W-1] ? lfps_pkg::ERR_W'(-filt_reg)
                                                 : lfps_pkg::ERR_W'(filt_reg);
        slow       = filt_mag >> lfps_pkg::SLOW_SHIFT;
        base_raw   = $signed(lfps_pkg::DRV_W'(base_speed_reg)) - $signed(lfps_pkg::DRV_W'(slow));
        base_sel   = (base_raw < lfps_pkg::DRV_W'(lfps_pkg::BASE_FLOOR))
                   ? lfps_pkg::DRV_W'(lfps_pkg::BASE_FLOOR) : base_raw;
        left_sum   = base_sel + steer_val;
        right_sum  = base_sel - steer_val;
    end

    // ------------------------------------------------------------------
    // control and state registers
    // ------------------------------------------------------------------
    always_comb
    begin
        base_speed_next = cfg_write_en ? cfg_write_data : base_speed_reg;
        if (drive_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lfps_pkg::ST_IDLE;
            base_speed_reg <= lfps_pkg::BASE_W'(lfps_pkg::BASE_SPEED_RESET);
            filt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_speed_reg <= base_speed_next;
            filt_reg       <= filt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (filt_load)
        begin
            prev_reg <= filt_reg;
        end
        if (drive_load)
        begin
            left_drive_reg   <= lfps_pkg::clamp_drive(left_sum);
            right_drive_reg  <= lfps_pkg::clamp_drive(right_sum);
            active_count_reg <= lfps_pkg::sat_count(merge_count);
            line_lost_reg    <= lost;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_drive   = left_drive_reg;
    assign right_drive  = right_drive_reg;
    assign active_count = active_count_reg;
    assign line_lost    = line_lost_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `LFPS_ASSERT_NEXT(a_accept_starts_merge, in_valid && in_ready, state_reg == lfps_pkg::ST_MERGE, "input transfer did not start the merge stage")
    `LFPS_ASSERT_NEXT(a_lost_holds_filter, filt_load && lost, filt_reg == $past(filt_reg), "filter moved while line lost")
    `LFPS_ASSERT_IMPL(a_lost_means_no_hits, out_valid && line_lost, active_count == '0, "line lost with active sensors")
    `LFPS_ASSERT_IMPL(a_drive_floor, out_valid, (left_drive >= lfps_pkg::DRIVE_W'(lfps_pkg::DRIVE_MIN)) && (right_drive >= lfps_pkg::DRIVE_W'(lfps_pkg::DRIVE_MIN)), "drive below floor")

endmodule

[tb/line_follow_pd_steering_unit_test.sv]
// ----------------------------------------------------------------------------
// line_follow_pd_steering_unit_test
// Self-checking bench for the line follower steering unit. Sensor samples go
// in through the input handshake. A scoreboard predicts each drive result from
// its own copy of the filtered error and base speed, and compares every
// result transfer field by field. The run covers a directed set, then random
// line-tracking runs, lost-line stretches and noise at several base speeds,
// with random gaps on both sides of the block.
// ----------------------------------------------------------------------------
module line_follow_pd_steering_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    // abort when nothing moves for this many cycles
    localparam int STALL_LIMIT  = 2000;
    // settle time after the last result
    localparam int TAIL_CYCLES  = 16;
    localparam int PHASE_ITEMS  = 250;
    localparam int PHASE_COUNT  = 6;
    localparam int DIRECTED_COUNT = 24;

    // directed samples: lost line from reset, both edge sensors, full bar,
    // center, long pushes to each side so the filter saturates, lost line
    // while steering hard, then alternating and paired patterns
    localparam logic [lfps_pkg::SENSOR_IN_W-1:0] DIRECTED [DIRECTED_COUNT] = '{
        8'h00, 8'h00, 8'h01, 8'h80, 8'hFF, 8'h18,
        8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h00, 8'h00,
        8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
        8'h55, 8'hAA, 8'h03, 8'hC0
    };

    typedef struct packed {
        logic [lfps_pkg::DRIVE_W-1:0]     left;
        logic [lfps_pkg::DRIVE_W-1:0]     right;
        logic [lfps_pkg::COUNT_OUT_W-1:0] count;
        logic                             lost;
    } drive_result_t;

    // ------------------------------------------------------------------------
    // Steering scoreboard: tracks the filtered error (Q5.10) and base speed,
    // predicts one drive result per accepted sample, checks results in order.
    // ------------------------------------------------------------------------
    class steering_scoreboard;
        logic signed [15:0]          filt_err;
        logic [lfps_pkg::BASE_W-1:0] base_speed;
        drive_result_t               drive_q[$];
        int                          mismatches;

        function new();
            filt_err   = '0;
            base_speed = lfps_pkg::BASE_W'(lfps_pkg::BASE_SPEED_RESET);
            mismatches = 0;
        endfunction

        function void set_base(logic [lfps_pkg::BASE_W-1:0] v);
            base_speed = v;
        endfunction

        function int pending();
            return drive_q.size();
        endfunction

        function int clamp_level(int v);
            if (v < 40)
                return 40;
            if (v > 255)
                return 255;
            return v;
        endfunction

        function void note_sample(logic [lfps_pkg::SENSOR_IN_W-1:0] bits);
            int            pos_sum;
            int            hits;
            int            err;
            int            prev;
            int            next_filt;
            int            steer;
            int            slowed;
            drive_result_t r;
            pos_sum = 0;
            hits    = 0;
            // weights -7..7, only the real sensors count
            for (int i = 0; i < lfps_pkg::SENSOR_COUNT; i++) begin
                if (bits[i]) begin
                    pos_sum += 2 * i - (lfps_pkg::SENSOR_COUNT - 1);
                    hits++;
                end
            end
            prev = filt_err;
            // int division truncates toward zero; lost line holds the error
            err = (hits > 0) ? (pos_sum * 1024) / hits : prev;
            // 0.7/0.3 low-pass, arithmetic shift = floor
            next_filt = (717 * prev + 307 * err) >>> 10;
            // 16*filt + 8*(filt - prev), truncated toward zero
            steer = (24 * next_filt - 8 * prev) / 1024;
            filt_err = 16'(next_filt);
            slowed = int'(base_speed) - (4 * ((next_filt < 0) ? -next_filt : next_filt)) / 1024;
            if (slowed < 70)
                slowed = 70;
            r.left  = lfps_pkg::DRIVE_W'(clamp_level(slowed + steer));
            r.right = lfps_pkg::DRIVE_W'(clamp_level(slowed - steer));
            r.count = lfps_pkg::COUNT_OUT_W'((hits > 15) ? 15 : hits);
            r.lost  = (hits == 0);
            drive_q.push_back(r);
        endfunction

        function void check_result(drive_result_t got);
            drive_result_t want;
            if (drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: left=%0d right=%0d count=%0d lost=%0b",
                             got.left, got.right, got.count, got.lost);
                return;
            end
            want = drive_q.pop_front();
            if (got.left != want.left || got.right != want.right ||
                got.count != want.count || got.lost != want.lost) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected left=%0d right=%0d count=%0d lost=%0b,",
                             want.left, want.right, want.count, want.lost,
                             " actual left=%0d right=%0d count=%0d lost=%0b",
                             got.left, got.right, got.count, got.lost);
            end
        endfunction
    endclass

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 cfg_write_en;
    logic [lfps_pkg::BASE_W-1:0]          cfg_write_data;
    logic                                 in_valid;
    logic                                 in_ready;
    logic [lfps_pkg::SENSOR_IN_W-1:0]     sensor_bits;
    logic                                 out_valid;
    logic                                 out_ready;
    logic [lfps_pkg::DRIVE_W-1:0]         left_drive;
    logic [lfps_pkg::DRIVE_W-1:0]         right_drive;
    logic [lfps_pkg::COUNT_OUT_W-1:0]     active_count;
    logic                                 line_lost;

    steering_scoreboard sb = new();

    // gap rates in percent, changed per phase
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;

    // random sample generator state: runs of one kind of track condition
    int run_left;
    int run_kind;
    int line_pos;

    line_follow_pd_steering_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sensor_bits    (sensor_bits),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_drive     (left_drive),
        .right_drive    (right_drive),
        .active_count   (active_count),
        .line_lost      (line_lost)
    );

    always #10 clk = ~clk;

    // Result side: check each transfer, then pick the next ready level.
    // Values read here are the ones the unit saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result('{left_drive, right_drive, active_count, line_lost});
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any transfer on either side clears the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // One sample transfer, with random gaps ahead of it. Valid stays high
    // between back-to-back items, so it is never dropped and raised in one step.
    task send_sample(input logic [lfps_pkg::SENSOR_IN_W-1:0] bits);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sensor_bits <= bits;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(bits);
    endtask

    // Stop sending and wait for every predicted result to come back.
    task drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // base_speed write; only called with the unit idle
    task write_base_speed(input logic [lfps_pkg::BASE_W-1:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.set_base(v);
    endtask

    // Mostly a line under the bar drifting by at most one sensor per sample,
    // with lost-line stretches, random noise, full bar and lone edge sensors.
    task make_sample(output logic [lfps_pkg::SENSOR_IN_W-1:0] s);
        int width;
        if (run_left == 0)
        begin
            run_left = $urandom_range(24, 1);
            run_kind = $urandom_range(9);
            line_pos = $urandom_range(lfps_pkg::SENSOR_COUNT - 1);
        end
        run_left--;
        if (run_kind <= 5)
        begin
            line_pos += $urandom_range(2) - 1;
            if (line_pos < 0)
                line_pos = 0;
            if (line_pos > lfps_pkg::SENSOR_COUNT - 1)
                line_pos = lfps_pkg::SENSOR_COUNT - 1;
            width = $urandom_range(3, 1);
            s = lfps_pkg::SENSOR_IN_W'(((1 << width) - 1) << line_pos);
        end
        else if (run_kind == 6)
            s = '0;
        else if (run_kind <= 8)
            s = lfps_pkg::SENSOR_IN_W'($urandom_range(255));
        else
        begin
            case ($urandom_range(2))
                0:       s = 8'hFF;
                1:       s = 8'h01;
                default: s = 8'h80;
            endcase
        end
    endtask

    initial
    begin
        logic [lfps_pkg::SENSOR_IN_W-1:0] sample;
        logic [lfps_pkg::BASE_W-1:0]      phase_base [PHASE_COUNT];

        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        sensor_bits    = '0;
        out_ready      = 1'b0;
        run_left       = 0;
        run_kind       = 0;
        line_pos       = 0;
        send_idle_pct  = 8;
        recv_idle_pct  = 56;

        // extremes, the floor edge and one below it, then random speeds
        phase_base[0] = 8'd255;
        phase_base[1] = 8'd0;
        phase_base[2] = 8'd70;
        phase_base[3] = 8'd69;
        phase_base[4] = lfps_pkg::BASE_W'($urandom_range(255));
        phase_base[5] = lfps_pkg::BASE_W'($urandom_range(255));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed set runs at the reset base speed
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_sample(DIRECTED[i]);
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            // sender dense / receiver busy, then swapped, then no gaps
            if (p < 2)
            begin
                send_idle_pct = 8;
                recv_idle_pct = 56;
            end
            else if (p < 4)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 8;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_base_speed(phase_base[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                make_sample(sample);
                send_sample(sample);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
